// ===== sv/des_pkg.sv =====
// Shared constants, request codes and controller/datapath types for the
// differential evolution step unit. No dependencies.
`timescale 1ns / 1ps
package des_pkg;

  localparam int MEMBER_COUNT = 64;
  localparam int MAX_DIMS = 16;
  localparam int MEMBER_W = $clog2(MEMBER_COUNT);
  localparam int DIM_W    = $clog2(MAX_DIMS);
  localparam int ADDR_W   = MEMBER_W + DIM_W;
  localparam int CNT_W    = DIM_W + 1;

  localparam logic [2:0] REQ_BOUNDS = 3'd0;
  localparam logic [2:0] REQ_LOAD   = 3'd1;
  localparam logic [2:0] REQ_TRIAL  = 3'd2;
  localparam logic [2:0] REQ_SCORE  = 3'd3;
  localparam logic [2:0] REQ_SELECT = 3'd4;
  localparam logic [2:0] REQ_READ   = 3'd5;

  localparam logic [1:0] RES_ZERO  = 2'd0;
  localparam logic [1:0] RES_TRIAL = 2'd1;
  localparam logic [1:0] RES_READ  = 2'd2;
  localparam logic [1:0] RES_REPL  = 2'd3;

  localparam logic [1:0] REG_MUTATION  = 2'd0;
  localparam logic [1:0] REG_CROSSOVER = 2'd1;
  localparam logic [1:0] REG_DIMS      = 2'd2;

  typedef struct packed {
    logic       capture;
    logic       wr_bounds;
    logic       wr_load;
    logic       rd_bc;
    logic       rd_am;
    logic       rd_elem;
    logic       latch_diff;
    logic       latch_prod;
    logic       latch_sum;
    logic       wr_trial;
    logic       wr_tscore;
    logic       rd_scores;
    logic       wr_pscore;
    logic       cp_rd;
    logic       cp_wr;
    logic       finish;
    logic [1:0] res_kind;
  } cmd_t;

  typedef struct packed {
    logic [2:0] req;
    logic       take;
    logic       n_zero;
    logic       copy_last;
  } status_t;

endpackage

// ===== sv/des_ctrl.sv =====
// Controller state machine for the differential evolution step unit.
// Depends on des_pkg; drives the datapath through cmd_t, watches status_t.
`timescale 1ns / 1ps
module des_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  des_pkg::status_t status,
  output des_pkg::cmd_t    cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ISSUE = 4'd1;
  localparam logic [3:0] S_RD2   = 4'd2;
  localparam logic [3:0] S_MUL   = 4'd3;
  localparam logic [3:0] S_ADD   = 4'd4;
  localparam logic [3:0] S_FIN   = 4'd5;
  localparam logic [3:0] S_CMP   = 4'd6;
  localparam logic [3:0] S_CPRD  = 4'd7;
  localparam logic [3:0] S_CPWR  = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = S_ISSUE;
        end
      end
      S_ISSUE: begin
        case (status.req)
          des_pkg::REQ_BOUNDS: begin
            cmd.wr_bounds = 1'b1;
            cmd.finish    = 1'b1;
            state_next    = S_IDLE;
          end
          des_pkg::REQ_LOAD: begin
            cmd.wr_load = 1'b1;
            cmd.finish  = 1'b1;
            state_next  = S_IDLE;
          end
          des_pkg::REQ_TRIAL: begin
            cmd.rd_bc  = 1'b1;
            state_next = S_RD2;
          end
          des_pkg::REQ_SCORE: begin
            cmd.wr_tscore = 1'b1;
            cmd.finish    = 1'b1;
            state_next    = S_IDLE;
          end
          des_pkg::REQ_SELECT: begin
            cmd.rd_scores = 1'b1;
            state_next    = S_CMP;
          end
          des_pkg::REQ_READ: begin
            cmd.rd_elem = 1'b1;
            state_next  = S_RD2;
          end
          default: begin
            cmd.finish = 1'b1;
            state_next = S_IDLE;
          end
        endcase
      end
      S_RD2: begin
        if (status.req == des_pkg::REQ_READ) begin
          cmd.finish   = 1'b1;
          cmd.res_kind = des_pkg::RES_READ;
          state_next   = S_IDLE;
        end else begin
          cmd.rd_am      = 1'b1;
          cmd.latch_diff = 1'b1;
          state_next     = S_MUL;
        end
      end
      S_MUL: begin
        cmd.latch_prod = 1'b1;
        state_next     = S_ADD;
      end
      S_ADD: begin
        cmd.latch_sum = 1'b1;
        state_next    = S_FIN;
      end
      S_FIN: begin
        cmd.wr_trial = 1'b1;
        cmd.finish   = 1'b1;
        cmd.res_kind = des_pkg::RES_TRIAL;
        state_next   = S_IDLE;
      end
      S_CMP: begin
        if (status.take) begin
          cmd.wr_pscore = 1'b1;
          if (status.n_zero) begin
            cmd.finish   = 1'b1;
            cmd.res_kind = des_pkg::RES_REPL;
            state_next   = S_IDLE;
          end else begin
            state_next = S_CPRD;
          end
        end else begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_CPRD: begin
        cmd.cp_rd  = 1'b1;
        state_next = S_CPWR;
      end
      S_CPWR: begin
        cmd.cp_wr = 1'b1;
        if (status.copy_last) begin
          cmd.finish   = 1'b1;
          cmd.res_kind = des_pkg::RES_REPL;
          state_next   = S_IDLE;
        end else begin
          state_next = S_CPRD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_capture_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |-> (state == S_IDLE))
    else $error("capture outside idle");
  a_finish_to_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> (state == S_IDLE))
    else $error("finish did not return to idle");
  a_copy_after_take: assert property (@(posedge clk) disable iff (rst)
    (state == S_CPRD) && $past(state == S_CMP) |-> $past(status.take))
    else $error("row copy without a better trial score");
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

endmodule

// ===== sv/des_datapath.sv =====
// Datapath for the differential evolution step unit: stores, score memories,
// mutation arithmetic, clamp and result registers. Depends on des_pkg.
`timescale 1ns / 1ps
module des_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  des_pkg::cmd_t                 cmd,
  output des_pkg::status_t              status,
  input  logic [17:0]                   mutation_scale,
  input  logic [16:0]                   crossover_rate,
  input  logic [4:0]                    active_dims,
  input  logic [2:0]                    req_type,
  input  logic [des_pkg::MEMBER_W-1:0]  member,
  input  logic [des_pkg::DIM_W-1:0]     dim,
  input  logic [des_pkg::MEMBER_W-1:0]  donor_base,
  input  logic [des_pkg::MEMBER_W-1:0]  donor_plus,
  input  logic [des_pkg::MEMBER_W-1:0]  donor_minus,
  input  logic [15:0]                   cross_draw,
  input  logic                          forced_cross,
  input  logic signed [31:0]            position_value,
  input  logic signed [31:0]            upper_value,
  input  logic [31:0]                   score_value,
  output logic signed [31:0]            result_value,
  output logic                          replaced,
  output logic                          bad_donors,
  output logic                          done
);

  logic [2:0]                  req_q;
  logic [des_pkg::MEMBER_W-1:0] member_q, base_q, plus_q, minus_q;
  logic [des_pkg::DIM_W-1:0]   dim_q;
  logic                        use_mut;
  logic                        bad_q;
  logic signed [31:0]          pos_q, upv_q;
  logic [31:0]                 score_q;
  logic [des_pkg::CNT_W-1:0]   cnt;
  logic [des_pkg::CNT_W-1:0]   n_eff;

  logic signed [31:0] pop_mem [des_pkg::MEMBER_COUNT*des_pkg::MAX_DIMS];
  logic signed [31:0] trial_mem [des_pkg::MEMBER_COUNT*des_pkg::MAX_DIMS];
  logic [31:0]        pscore_mem [des_pkg::MEMBER_COUNT];
  logic [31:0]        tscore_mem [des_pkg::MEMBER_COUNT];
  logic [des_pkg::MEMBER_COUNT-1:0] pscore_vld, tscore_vld;
  logic signed [31:0] lower_lim [des_pkg::MAX_DIMS];
  logic signed [31:0] upper_lim [des_pkg::MAX_DIMS];

  logic signed [31:0] pop_rd0, pop_rd1, trial_rd;
  logic [31:0]        ps_rd, ts_rd;
  logic               ps_rd_vld, ts_rd_vld;
  logic [31:0]        ps_eff, ts_eff;

  logic [des_pkg::ADDR_W-1:0] pop_ra0, pop_ra1, pop_wa, trial_wa, trial_ra;
  logic                       pop_re, pop_we, trial_we;
  logic signed [31:0]         pop_wd, trial_wd;

  logic signed [32:0] diff;
  logic signed [31:0] base_val, tgt_val;
  logic signed [51:0] prod;
  logic signed [36:0] sum;
  logic signed [51:0] prod_rnd;
  logic signed [36:0] lo_ext, hi_ext;
  logic signed [31:0] trial_val;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q    <= req_type;
      member_q <= member;
      dim_q    <= dim;
      base_q   <= donor_base;
      plus_q   <= donor_plus;
      minus_q  <= donor_minus;
      use_mut  <= ({1'b0, cross_draw} < crossover_rate) || forced_cross;
      bad_q    <= (donor_base == donor_plus) || (donor_base == donor_minus) ||
                  (donor_plus == donor_minus) || (donor_base == member) ||
                  (donor_plus == member) || (donor_minus == member);
      pos_q    <= position_value;
      upv_q    <= upper_value;
      score_q  <= score_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.capture) begin
      cnt <= '0;
    end else if (cmd.cp_wr) begin
      cnt <= cnt + 1'b1;
    end
  end

  assign n_eff = (active_dims > des_pkg::CNT_W'(des_pkg::MAX_DIMS)) ?
                 des_pkg::CNT_W'(des_pkg::MAX_DIMS) : active_dims;

  assign status.req       = req_q;
  assign status.n_zero    = (n_eff == '0);
  assign status.copy_last = ((cnt + 1'b1) == n_eff);
  assign ps_eff           = ps_rd_vld ? ps_rd : '1;
  assign ts_eff           = ts_rd_vld ? ts_rd : '1;
  assign status.take      = (ts_eff < ps_eff);

  always_comb begin
    pop_ra0 = {member_q, dim_q};
    pop_ra1 = {member_q, dim_q};
    if (cmd.rd_bc) begin
      pop_ra0 = {plus_q, dim_q};
      pop_ra1 = {minus_q, dim_q};
    end else if (cmd.rd_am) begin
      pop_ra0 = {base_q, dim_q};
    end
  end
  assign pop_re = cmd.rd_bc || cmd.rd_am || cmd.rd_elem;

  assign pop_we = cmd.wr_load || cmd.cp_wr;
  assign pop_wa = cmd.cp_wr ? {member_q, cnt[des_pkg::DIM_W-1:0]} : {member_q, dim_q};
  assign pop_wd = cmd.cp_wr ? trial_rd : pos_q;

  assign trial_we = cmd.wr_load || cmd.wr_trial;
  assign trial_wa = {member_q, dim_q};
  assign trial_wd = cmd.wr_trial ? trial_val : pos_q;
  assign trial_ra = {member_q, cnt[des_pkg::DIM_W-1:0]};

  always_ff @(posedge clk) begin
    if (pop_we) begin
      pop_mem[pop_wa] <= pop_wd;
    end
    if (pop_re) begin
      pop_rd0 <= pop_mem[pop_ra0];
      pop_rd1 <= pop_mem[pop_ra1];
    end
  end

  always_ff @(posedge clk) begin
    if (trial_we) begin
      trial_mem[trial_wa] <= trial_wd;
    end
    if (cmd.cp_rd) begin
      trial_rd <= trial_mem[trial_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_tscore) begin
      tscore_mem[member_q] <= score_q;
    end
    if (cmd.wr_pscore) begin
      pscore_mem[member_q] <= ts_eff;
    end
    if (cmd.rd_scores) begin
      ts_rd <= tscore_mem[member_q];
      ps_rd <= pscore_mem[member_q];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tscore_vld <= '0;
      pscore_vld <= '0;
      ts_rd_vld  <= 1'b0;
      ps_rd_vld  <= 1'b0;
    end else begin
      if (cmd.wr_tscore) begin
        tscore_vld[member_q] <= 1'b1;
      end
      if (cmd.wr_pscore) begin
        pscore_vld[member_q] <= 1'b1;
      end
      if (cmd.rd_scores) begin
        ts_rd_vld <= tscore_vld[member_q];
        ps_rd_vld <= pscore_vld[member_q];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_bounds) begin
      lower_lim[dim_q] <= pos_q;
      upper_lim[dim_q] <= upv_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_diff) begin
      diff <= 33'(pop_rd0) - 33'(pop_rd1);
    end
    if (cmd.latch_prod) begin
      prod     <= diff * $signed({1'b0, mutation_scale});
      base_val <= pop_rd0;
      tgt_val  <= pop_rd1;
    end
    if (cmd.latch_sum) begin
      sum <= 37'(base_val) + 37'(prod_rnd >>> 16);
    end
  end

  assign prod_rnd = prod + 52'sd32768;
  assign lo_ext   = 37'(lower_lim[dim_q]);
  assign hi_ext   = 37'(upper_lim[dim_q]);

  always_comb begin
    if (!use_mut) begin
      trial_val = tgt_val;
    end else if (sum < lo_ext) begin
      trial_val = lower_lim[dim_q];
    end else if (sum > hi_ext) begin
      trial_val = upper_lim[dim_q];
    end else begin
      trial_val = sum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      case (cmd.res_kind)
        des_pkg::RES_TRIAL: begin
          result_value <= trial_val;
          replaced     <= 1'b0;
          bad_donors   <= bad_q;
        end
        des_pkg::RES_READ: begin
          result_value <= pop_rd0;
          replaced     <= 1'b0;
          bad_donors   <= 1'b0;
        end
        des_pkg::RES_REPL: begin
          result_value <= '0;
          replaced     <= 1'b1;
          bad_donors   <= 1'b0;
        end
        default: begin
          result_value <= '0;
          replaced     <= 1'b0;
          bad_donors   <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ===== sv/differential_evolution_step_unit.sv =====
// Top level of the differential evolution step unit: APB register file,
// controller and datapath. Depends on des_pkg, des_ctrl, des_datapath.
//
//   channel   | handshake              | payload
//   request   | start / busy           | req_type .. score_value
//   result    | done (one-cycle strobe) | result_value, replaced, bad_donors
//   registers | APB psel/penable/pwrite | paddr, pwdata, prdata
//
// Bounds, load, score and unused codes finish in the issue state; read ends
// after its memory read; trial element: two population memory read rounds,
// multiply, add, clamp. Select copies the trial row when the trial wins.
// done follows the last cycle of a transaction; busy drops in that cycle.
// rst is synchronous; score memories read as all ones until written.
// The result side cannot stall; each result is flagged by done for one cycle.
`timescale 1ns / 1ps
module differential_evolution_step_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [2:0]                    req_type,
  input  logic [des_pkg::MEMBER_W-1:0]  member,
  input  logic [des_pkg::DIM_W-1:0]     dim,
  input  logic [des_pkg::MEMBER_W-1:0]  donor_base,
  input  logic [des_pkg::MEMBER_W-1:0]  donor_plus,
  input  logic [des_pkg::MEMBER_W-1:0]  donor_minus,
  input  logic [15:0]                   cross_draw,
  input  logic                          forced_cross,
  input  logic signed [31:0]            position_value,
  input  logic signed [31:0]            upper_value,
  input  logic [31:0]                   score_value,
  output logic signed [31:0]            result_value,
  output logic                          replaced,
  output logic                          bad_donors,
  output logic                          done,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [3:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  logic [17:0]      mutation_scale;
  logic [16:0]      crossover_rate;
  logic [4:0]       active_dims;
  logic             cfg_wr;
  des_pkg::cmd_t    cmd;
  des_pkg::status_t status;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      mutation_scale <= 18'd32768;
      crossover_rate <= 17'd58982;
      active_dims    <= 5'd16;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        des_pkg::REG_MUTATION:  mutation_scale <= pwdata[17:0];
        des_pkg::REG_CROSSOVER: crossover_rate <= pwdata[16:0];
        des_pkg::REG_DIMS:      active_dims    <= pwdata[4:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      des_pkg::REG_MUTATION:  prdata = {14'd0, mutation_scale};
      des_pkg::REG_CROSSOVER: prdata = {15'd0, crossover_rate};
      des_pkg::REG_DIMS:      prdata = {27'd0, active_dims};
      default:                prdata = '0;
    endcase
  end

  des_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  des_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .mutation_scale (mutation_scale),
    .crossover_rate (crossover_rate),
    .active_dims    (active_dims),
    .req_type       (req_type),
    .member         (member),
    .dim            (dim),
    .donor_base     (donor_base),
    .donor_plus     (donor_plus),
    .donor_minus    (donor_minus),
    .cross_draw     (cross_draw),
    .forced_cross   (forced_cross),
    .position_value (position_value),
    .upper_value    (upper_value),
    .score_value    (score_value),
    .result_value   (result_value),
    .replaced       (replaced),
    .bad_donors     (bad_donors),
    .done           (done)
  );

endmodule
